// ===== src/frsm_pkg.sv =====
// Package for the flash record slot manager: opcode and status codes,
// input and result beat payload types. No dependencies.
package frsm_pkg;

  localparam int unsigned SlotFieldW = 6;
  localparam int unsigned SeqW       = 8;

  localparam logic [SeqW-1:0] SeqEmpty    = 8'hFF;
  localparam logic [SeqW-1:0] SeqReset    = 8'hFE;
  localparam logic [SeqW-1:0] SeqWrapLast = 8'hFF;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_SCAN    = 2'd1,
    OP_VERDICT = 2'd2,
    OP_COMMIT  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NONE      = 3'd1,
    ST_EARLIER   = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_RECOVERED = 3'd4
  } status_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [SlotFieldW-1:0] slot_number;
    logic [SeqW-1:0]       seq_value;
    logic                  checksum_ok;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic                  found;
    logic [SlotFieldW-1:0] chosen_slot;
    logic [SeqW-1:0]       next_seq;
    logic [SlotFieldW-1:0] write_slot;
    logic                  write_enable;
    logic                  erase_first_page;
    logic                  erase_second_page;
  } out_item_t;

endpackage

// ===== src/frsm_in_if.sv =====
// Input channel of the slot manager: valid/ready handshake with a command beat.
// Depends on frsm_pkg.
interface frsm_in_if;
  import frsm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/frsm_out_if.sv =====
// Result channel of the slot manager: valid/ready handshake with a result beat.
// Depends on frsm_pkg.
interface frsm_out_if;
  import frsm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/frsm_hdr_ram.sv =====
// Slot header store: one write port, one registered read port with
// write-to-read forwarding on an address match. No dependencies.
module frsm_hdr_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned DataW = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/flash_record_slot_manager_top.sv =====
// Flash record slot manager: one command beat in, one result beat out.
// The result beat is registered; throughput 1 beat per cycle while the result
// channel is ready, set by the single state update and the registered header
// read at the next selected slot. Reset clears the selection, sets the sequence
// to 254 and empties the result register; the header store is not cleared.
// Depends on frsm_pkg, frsm_in_if, frsm_out_if and frsm_hdr_ram.
module flash_record_slot_manager_top #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  frsm_in_if.sink    in_i,
  frsm_out_if.source out_o
);
  import frsm_pkg::*;

  localparam int unsigned SlotW  = $clog2(SLOT_COUNT);
  localparam int unsigned TriesW = $clog2(SLOT_COUNT + 1);

  localparam logic [SlotW-1:0]  SlotLast  = SlotW'(SLOT_COUNT - 1);
  localparam logic [SlotW-1:0]  SlotHalf  = SlotW'(SLOT_COUNT / 2);
  localparam logic [TriesW-1:0] TriesMax  = TriesW'(SLOT_COUNT);
  localparam logic [SeqW:0]     SeqWindow = (SeqW + 1)'(SLOT_COUNT);
  localparam logic [SlotFieldW+1:0] SlotLimit = (SlotFieldW + 2)'(SLOT_COUNT);

  logic [SlotW-1:0] mod_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_mod_tab
    assign mod_tab[g] = SlotW'(g % SLOT_COUNT);
  end

  logic [SeqW-1:0]   best_seq_q, best_seq_d;
  logic [SlotW-1:0]  sel_q, sel_d;
  logic              have_q, have_d;
  logic [SeqW-1:0]   cur_q, cur_d;
  logic              fail_q, fail_d;
  logic [TriesW-1:0] tries_q, tries_d;
  logic              out_valid_q;
  out_item_t         out_q, out_d;

  logic              hdr_we;
  logic [SlotW-1:0]  hdr_waddr;
  logic [SeqW-1:0]   hdr_wdata;
  logic [SeqW-1:0]   hdr_sel;

  logic              accept;
  in_item_t          cmd;
  logic [SlotW-1:0]  cmd_slot;
  logic [SeqW-1:0]   seq_diff;
  logic              take;
  logic [SeqW-1:0]   seq_next;
  logic [SlotW-1:0]  wslot;
  logic [TriesW-1:0] tries_inc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign cmd        = in_i.payload;
  assign cmd_slot   = SlotW'(cmd.slot_number);
  assign seq_diff   = cmd.seq_value - best_seq_q;
  assign take       = !have_q ||
                      ((best_seq_q < cmd.seq_value) && ({1'b0, seq_diff} < SeqWindow));
  assign seq_next   = (cur_q + 8'd1 == SeqWrapLast) ? '0 : cur_q + 8'd1;
  assign wslot      = mod_tab[seq_next];
  assign tries_inc  = tries_q + TriesW'(1);

  always_comb begin
    best_seq_d = best_seq_q;
    sel_d      = sel_q;
    have_d     = have_q;
    cur_d      = cur_q;
    fail_d     = fail_q;
    tries_d    = tries_q;
    hdr_we     = 1'b0;
    hdr_waddr  = cmd_slot;
    hdr_wdata  = cmd.seq_value;
    out_d      = '0;
    out_d.status = ST_OK;

    if (accept) begin
      unique case (cmd.opcode)
        OP_CLEAR: begin
          best_seq_d = SeqEmpty;
          sel_d      = '0;
          have_d     = 1'b0;
          fail_d     = 1'b0;
          tries_d    = '0;
        end
        OP_SCAN: begin
          if ({2'b00, cmd.slot_number} < SlotLimit) begin
            hdr_we = 1'b1;
            if ((cmd.seq_value != SeqEmpty) && take) begin
              best_seq_d = cmd.seq_value;
              sel_d      = cmd_slot;
              have_d     = 1'b1;
            end
          end
        end
        OP_VERDICT: begin
          priority if (!have_q) begin
            out_d.status = ST_NONE;
          end else if (tries_q >= TriesMax) begin
            out_d.status = ST_EXHAUSTED;
          end else begin
            tries_d = tries_inc;
            cur_d   = (hdr_sel == SeqEmpty) ? SeqReset : hdr_sel;
            if (cmd.checksum_ok) begin
              if (fail_q) begin
                cur_d     = '0;
                sel_d     = '0;
                hdr_we    = 1'b1;
                hdr_waddr = '0;
                hdr_wdata = '0;
                out_d.write_enable      = 1'b1;
                out_d.erase_first_page  = 1'b1;
                out_d.erase_second_page = 1'b1;
                out_d.status            = ST_RECOVERED;
              end
              fail_d  = 1'b0;
              tries_d = '0;
            end else begin
              fail_d = 1'b1;
              sel_d  = (sel_q == '0) ? SlotLast : sel_q - SlotW'(1);
              out_d.status = (tries_inc >= TriesMax) ? ST_EXHAUSTED : ST_EARLIER;
            end
          end
        end
        OP_COMMIT: begin
          cur_d     = seq_next;
          hdr_we    = 1'b1;
          hdr_waddr = wslot;
          hdr_wdata = seq_next;
          out_d.write_slot        = SlotFieldW'(wslot);
          out_d.write_enable      = 1'b1;
          out_d.erase_first_page  = (wslot == '0);
          out_d.erase_second_page = (wslot == SlotHalf);
        end
        default: begin
          out_d.status = ST_OK;
        end
      endcase
    end

    out_d.found       = have_d;
    out_d.chosen_slot = SlotFieldW'(sel_d);
    out_d.next_seq    = cur_d;
  end

  frsm_hdr_ram #(
    .Depth (SLOT_COUNT),
    .DataW (SeqW)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (hdr_waddr),
    .wdata_i (hdr_wdata),
    .raddr_i (sel_d),
    .rdata_o (hdr_sel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_seq_q  <= SeqEmpty;
      sel_q       <= '0;
      have_q      <= 1'b0;
      cur_q       <= SeqReset;
      fail_q      <= 1'b0;
      tries_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      best_seq_q <= best_seq_d;
      sel_q      <= sel_d;
      have_q     <= have_d;
      cur_q      <= cur_d;
      fail_q     <= fail_d;
      tries_q    <= tries_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

`ifndef SYNTHESIS
  a_tries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tries_q <= TriesMax)
    else $error("retry count beyond slot count");

  a_no_sel_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_q |-> (sel_q == '0) && (best_seq_q == SeqEmpty))
    else $error("selection state without a selected slot");

  a_seq_never_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q != SeqEmpty)
    else $error("current sequence holds the empty marker");

  a_recover_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == ST_RECOVERED) |->
      out_q.erase_first_page && out_q.erase_second_page &&
      out_q.write_enable && (out_q.write_slot == '0) && (out_q.next_seq == '0))
    else $error("recovery beat without full erase and restart");
`endif

endmodule
